/* rtl/modulation_bus_processor_macros.svh */
// Assertion macros shared by the modulation bus processor RTL.
`ifndef MODULATION_BUS_PROCESSOR_MACROS_SVH
`define MODULATION_BUS_PROCESSOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mbp_pkg.sv */
// Types, constants and helpers of the modulation bus processor.
package mbp_pkg;

  // Sample format and derived widths
  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = SAMPLE_W - 1;
  localparam int LVL_W      = SAMPLE_W + 2;
  localparam int COEF_W     = 16;
  localparam int STEP_W     = 16;
  localparam int HOLD_W     = 16;
  localparam int THR_W      = FRAC_W;
  localparam int WIDE_BASE  = (SAMPLE_W > COEF_W) ? SAMPLE_W : COEF_W;
  localparam int POLE_W     = WIDE_BASE + 3;
  localparam int MX_W       = WIDE_BASE + 1;
  localparam int PROD_W     = MX_W + POLE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (THR_W > COEF_W) ? THR_W : COEF_W;

  // Full scale, overshoot and end-of-decay levels
  localparam longint ONE_I  = longint'(1) << FRAC_W;
  localparam longint OVER_I = (ONE_I + 50) / 100;
  localparam longint END_I  = (ONE_I + 500) / 1000;

  localparam logic signed [POLE_W-1:0] ONE_P     = POLE_W'(ONE_I);
  localparam logic signed [POLE_W-1:0] SMAX_P    = POLE_W'(ONE_I - 1);
  localparam logic signed [POLE_W-1:0] SMIN_P    = POLE_W'(-ONE_I);
  localparam logic signed [POLE_W-1:0] ATK_TGT_P = POLE_W'(ONE_I + OVER_I);
  localparam logic signed [POLE_W-1:0] DEC_TGT_P = POLE_W'(-OVER_I);
  localparam logic signed [POLE_W-1:0] END_P     = POLE_W'(END_I);
  localparam logic signed [LVL_W-1:0]  ONE_LVL   = LVL_W'(ONE_I);

  // Rounding offsets for the coefficient and sample products
  localparam logic signed [PROD_W-1:0] RND_COEF = PROD_W'(longint'(1) << (COEF_W - 1));
  localparam logic signed [PROD_W-1:0] RND_FRAC = PROD_W'(longint'(1) << (FRAC_W - 1));

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_MUL     = 4'd1,
    OP_MIN     = 4'd2,
    OP_MAX     = 4'd3,
    OP_GATE    = 4'd4,
    OP_XFADE   = 4'd5,
    OP_DIFF    = 4'd6,
    OP_FOLLOW  = 4'd7,
    OP_TRIGGER = 4'd8,
    OP_SLEWEXP = 4'd9,
    OP_SLEWLIN = 4'd10
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED    = 3'd0,
    REG_OP         = 3'd1,
    REG_THRESHOLD  = 3'd2,
    REG_HOLD_TICKS = 3'd3,
    REG_COEF_UP    = 3'd4,
    REG_COEF_DOWN  = 3'd5,
    REG_STEP_UP    = 3'd6,
    REG_STEP_DOWN  = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ATTACK = 4'b0010,
    PH_HOLD   = 4'b0100,
    PH_DECAY  = 4'b1000
  } env_phase_t;

  typedef struct packed {
    logic              enabled;
    op_t               op;
    logic [THR_W-1:0]  threshold;
    logic [HOLD_W-1:0] hold_ticks;
    logic [COEF_W-1:0] coef_up;
    logic [COEF_W-1:0] coef_down;
    logic [STEP_W-1:0] step_up;
    logic [STEP_W-1:0] step_down;
  } cfg_t;

  // Envelope view handed to the arithmetic unit
  typedef struct packed {
    env_phase_t              phase;
    logic signed [LVL_W-1:0] level;
  } env_view_t;

  // Clamp a wide value into the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [POLE_W-1:0] x
  );
    logic signed [POLE_W-1:0] c;
    c = (x > SMAX_P) ? SMAX_P : ((x < SMIN_P) ? SMIN_P : x);
    return c[SAMPLE_W-1:0];
  endfunction

endpackage

/* rtl/mbp_if.sv */
// Stream interfaces for the sample and result channels.
interface mbp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mbp_pkg::SAMPLE_W-1:0]  sample_a;
  logic signed [mbp_pkg::SAMPLE_W-1:0]  sample_b;

  modport source (output valid, output sample_a, output sample_b, input ready);
  modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

interface mbp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mbp_pkg::SAMPLE_W-1:0]  bus_value;

  modport source (output valid, output bus_value, input ready);
  modport sink   (input valid, input bus_value, output ready);
endinterface

/* rtl/mbp_env.sv */
// Trigger envelope sequencer: phase, hold counter and previous magnitude.
module mbp_env (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 upd,
  input  logic signed [mbp_pkg::SAMPLE_W-1:0]  sample_a,
  input  mbp_pkg::cfg_t                        cfg,
  input  logic signed [mbp_pkg::POLE_W-1:0]    pole_res,
  output mbp_pkg::env_view_t                   view
);

  mbp_pkg::env_phase_t                  phase_r, phase_nxt, ph_eff;
  logic [mbp_pkg::HOLD_W-1:0]           hold_cnt_r, hold_cnt_nxt, hc_eff, hc_dec;
  logic [mbp_pkg::THR_W-1:0]            prev_mag_r, mag;
  logic signed [mbp_pkg::SAMPLE_W:0]    a_x;
  logic [mbp_pkg::SAMPLE_W:0]           abs_u;
  logic signed [mbp_pkg::LVL_W-1:0]     lvl;
  logic                                 trig;

  // Magnitude, full-scale negative folded to the largest positive sample
  assign a_x   = (mbp_pkg::SAMPLE_W + 1)'(sample_a);
  assign abs_u = (a_x < 0) ? (mbp_pkg::SAMPLE_W + 1)'(-a_x) : (mbp_pkg::SAMPLE_W + 1)'(a_x);
  assign mag   = abs_u[mbp_pkg::FRAC_W] ? '1 : abs_u[mbp_pkg::FRAC_W-1:0];

  // Upward crossing restarts the envelope from idle or decay
  assign trig = (mag > cfg.threshold) && (prev_mag_r <= cfg.threshold) &&
                ((phase_r == mbp_pkg::PH_IDLE) || (phase_r == mbp_pkg::PH_DECAY));

  assign ph_eff = trig ? mbp_pkg::PH_ATTACK : phase_r;
  assign hc_eff = trig ? cfg.hold_ticks : hold_cnt_r;
  assign hc_dec = (hc_eff != '0) ? hc_eff - mbp_pkg::HOLD_W'(1) : '0;

  // Advance the phase and pick this tick's level
  always_comb begin
    phase_nxt    = ph_eff;
    hold_cnt_nxt = hc_eff;
    lvl          = '0;
    case (ph_eff)
      mbp_pkg::PH_IDLE: begin
        lvl = '0;
      end
      mbp_pkg::PH_ATTACK: begin
        if (pole_res >= mbp_pkg::ONE_P) begin
          lvl       = mbp_pkg::ONE_LVL;
          phase_nxt = (cfg.hold_ticks != '0) ? mbp_pkg::PH_HOLD : mbp_pkg::PH_DECAY;
        end else begin
          lvl = pole_res[mbp_pkg::LVL_W-1:0];
        end
      end
      mbp_pkg::PH_HOLD: begin
        lvl          = mbp_pkg::ONE_LVL;
        hold_cnt_nxt = hc_dec;
        if (hc_dec == '0) begin
          phase_nxt = mbp_pkg::PH_DECAY;
        end
      end
      mbp_pkg::PH_DECAY: begin
        if (pole_res <= mbp_pkg::END_P) begin
          lvl       = '0;
          phase_nxt = mbp_pkg::PH_IDLE;
        end else begin
          lvl = pole_res[mbp_pkg::LVL_W-1:0];
        end
      end
      default: begin
        lvl       = '0;
        phase_nxt = mbp_pkg::PH_IDLE;
      end
    endcase
  end

  assign view.phase = ph_eff;
  assign view.level = lvl;

  // Commit envelope state only on ticks of an enabled bus in trigger mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mbp_pkg::PH_IDLE;
      hold_cnt_r <= '0;
      prev_mag_r <= '0;
    end else if (upd) begin
      phase_r    <= phase_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      prev_mag_r <= mag;
    end
  end

endmodule

/* rtl/mbp_alu.sv */
// Per-tick arithmetic: combinators, shared one-pole multiplier and slew.
module mbp_alu (
  input  logic signed [mbp_pkg::SAMPLE_W-1:0]  sample_a,
  input  logic signed [mbp_pkg::SAMPLE_W-1:0]  sample_b,
  input  logic signed [mbp_pkg::LVL_W-1:0]     level,
  input  mbp_pkg::cfg_t                        cfg,
  input  mbp_pkg::env_view_t                   env,
  output logic signed [mbp_pkg::POLE_W-1:0]    pole_res,
  output logic signed [mbp_pkg::LVL_W-1:0]     level_nxt
);

  localparam int PW = mbp_pkg::POLE_W;
  localparam int LW = mbp_pkg::LVL_W;

  logic signed [PW-1:0]                ax, bx, lx, absa, tgt, diff, sum_ab, dif_ab, abs_dab;
  logic signed [PW-1:0]                slew_d, su, sd, mul_v, fol_v;
  logic signed [mbp_pkg::MX_W-1:0]     m_x;
  logic signed [PW-1:0]                m_y;
  logic signed [mbp_pkg::PROD_W-1:0]   prod, pole_sum, pole_sh, mul_sum, mul_sh;
  logic [mbp_pkg::COEF_W-1:0]          coef;
  logic                                rising, is_mul;

  assign ax     = PW'(sample_a);
  assign bx     = PW'(sample_b);
  assign lx     = PW'(level);
  assign absa   = (ax < 0) ? -ax : ax;
  assign is_mul = (cfg.op == mbp_pkg::OP_MUL);

  // Pick the one-pole target and direction
  always_comb begin
    case (cfg.op)
      mbp_pkg::OP_FOLLOW: begin
        tgt    = absa;
        rising = (absa > lx);
      end
      mbp_pkg::OP_TRIGGER: begin
        rising = (env.phase == mbp_pkg::PH_ATTACK);
        tgt    = rising ? mbp_pkg::ATK_TGT_P : mbp_pkg::DEC_TGT_P;
      end
      mbp_pkg::OP_SLEWEXP: begin
        tgt    = ax;
        rising = (ax > lx);
      end
      default: begin
        tgt    = ax;
        rising = 1'b0;
      end
    endcase
  end

  assign coef = rising ? cfg.coef_up : cfg.coef_down;
  assign diff = lx - tgt;

  // Shared multiplier: sample product or coefficient times distance
  assign m_x  = is_mul ? mbp_pkg::MX_W'(sample_a) : $signed(mbp_pkg::MX_W'(coef));
  assign m_y  = is_mul ? bx : diff;
  assign prod = mbp_pkg::PROD_W'(m_x) * mbp_pkg::PROD_W'(m_y);

  // Round half up, then shift down
  assign pole_sum = prod + mbp_pkg::RND_COEF;
  assign pole_sh  = pole_sum >>> mbp_pkg::COEF_W;
  assign pole_res = tgt + pole_sh[PW-1:0];
  assign mul_sum  = prod + mbp_pkg::RND_FRAC;
  assign mul_sh   = mul_sum >>> mbp_pkg::FRAC_W;
  assign mul_v    = mul_sh[PW-1:0];

  // Combinator helpers
  assign sum_ab  = ax + bx;
  assign dif_ab  = ax - bx;
  assign abs_dab = (dif_ab < 0) ? -dif_ab : dif_ab;

  // Follower clamps to [0, full scale]
  assign fol_v = (pole_res < 0) ? '0 :
                 ((pole_res > mbp_pkg::ONE_P) ? mbp_pkg::ONE_P : pole_res);

  // Linear slew: limit the step in each direction
  assign su = PW'(cfg.step_up);
  assign sd = PW'(cfg.step_down);
  always_comb begin
    slew_d = ax - lx;
    if (slew_d > su) begin
      slew_d = su;
    end
    if (slew_d < -sd) begin
      slew_d = -sd;
    end
  end

  // Select the new level
  always_comb begin
    case (cfg.op)
      mbp_pkg::OP_ADD:     level_nxt = LW'(mbp_pkg::sat_sample(sum_ab));
      mbp_pkg::OP_MUL:     level_nxt = LW'(mbp_pkg::sat_sample(mul_v));
      mbp_pkg::OP_MIN:     level_nxt = LW'((ax < bx) ? sample_a : sample_b);
      mbp_pkg::OP_MAX:     level_nxt = LW'((ax > bx) ? sample_a : sample_b);
      mbp_pkg::OP_GATE:    level_nxt = (ax > 0) ? LW'(sample_b) : '0;
      mbp_pkg::OP_XFADE:   level_nxt = LW'(sum_ab >>> 1);
      mbp_pkg::OP_DIFF:    level_nxt = LW'(mbp_pkg::sat_sample(abs_dab));
      mbp_pkg::OP_FOLLOW:  level_nxt = fol_v[LW-1:0];
      mbp_pkg::OP_TRIGGER: level_nxt = env.level;
      mbp_pkg::OP_SLEWEXP: level_nxt = pole_res[LW-1:0];
      mbp_pkg::OP_SLEWLIN: level_nxt = LW'(lx + slew_d);
      default:             level_nxt = '0;
    endcase
  end

endmodule

/* rtl/modulation_bus_processor.sv */
// Top level of the modulation bus processor: handshake, registers and state.
//
//   port      dir   handshake        payload
//   in_ch     in    valid / ready    sample_a, sample_b (signed Q1.15)
//   out_ch    out   valid / ready    bus_value (signed Q1.15)
//   cfg_*     in    cfg_we only      cfg_idx, cfg_wdata
//
// One word per cycle sustained while out_ch.ready stays high; an accepted word
// goes from the input register to the output register that drives out_ch. The
// combinational level loop (subtract, multiply, two adds) sets that rate.
// Reset is synchronous: clears valids, envelope state and level, and loads
// the register defaults. When out_ch stalls, one more word fits in the input
// register, then in_ch.ready drops.
`include "modulation_bus_processor_macros.svh"

module modulation_bus_processor (
  input  logic                               clk,
  input  logic                               rst_n,
  mbp_in_if.sink                             in_ch,
  mbp_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [mbp_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [mbp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam mbp_pkg::cfg_t CFG_RST = '{
    enabled:    1'b0,
    op:         mbp_pkg::OP_ADD,
    threshold:  '0,
    hold_ticks: '0,
    coef_up:    '0,
    coef_down:  '0,
    step_up:    '1,
    step_down:  '1
  };

  mbp_pkg::cfg_t                          cfg_r;
  mbp_pkg::env_view_t                     env_view;
  logic                                   s1_v_r, out_v_r;
  logic signed [mbp_pkg::SAMPLE_W-1:0]    s1_a_r, s1_b_r;
  logic signed [mbp_pkg::SAMPLE_W-1:0]    out_data_r, out_data_nxt;
  logic signed [mbp_pkg::LVL_W-1:0]       level_r, level_nxt;
  logic signed [mbp_pkg::POLE_W-1:0]      pole_res;
  logic                                   adv, in_acc, step, trig_upd;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else if (cfg_we) begin
      case (mbp_pkg::cfg_idx_t'(cfg_idx))
        mbp_pkg::REG_ENABLED:    cfg_r.enabled    <= cfg_wdata[0];
        mbp_pkg::REG_OP:         cfg_r.op         <= mbp_pkg::op_t'(cfg_wdata[3:0]);
        mbp_pkg::REG_THRESHOLD:  cfg_r.threshold  <= cfg_wdata[mbp_pkg::THR_W-1:0];
        mbp_pkg::REG_HOLD_TICKS: cfg_r.hold_ticks <= cfg_wdata[mbp_pkg::HOLD_W-1:0];
        mbp_pkg::REG_COEF_UP:    cfg_r.coef_up    <= cfg_wdata[mbp_pkg::COEF_W-1:0];
        mbp_pkg::REG_COEF_DOWN:  cfg_r.coef_down  <= cfg_wdata[mbp_pkg::COEF_W-1:0];
        mbp_pkg::REG_STEP_UP:    cfg_r.step_up    <= cfg_wdata[mbp_pkg::STEP_W-1:0];
        mbp_pkg::REG_STEP_DOWN:  cfg_r.step_down  <= cfg_wdata[mbp_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: advance the pipe whenever the output register frees up
  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign step        = s1_v_r && adv;
  assign trig_upd    = step && cfg_r.enabled && (cfg_r.op == mbp_pkg::OP_TRIGGER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_a_r <= in_ch.sample_a;
      s1_b_r <= in_ch.sample_b;
    end
  end

  mbp_env u_env (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (trig_upd),
    .sample_a (s1_a_r),
    .cfg      (cfg_r),
    .pole_res (pole_res),
    .view     (env_view)
  );

  mbp_alu u_alu (
    .sample_a  (s1_a_r),
    .sample_b  (s1_b_r),
    .level     (level_r),
    .cfg       (cfg_r),
    .env       (env_view),
    .pole_res  (pole_res),
    .level_nxt (level_nxt)
  );

  // Disabled bus drops to zero and keeps its level
  assign out_data_nxt = cfg_r.enabled ?
                        mbp_pkg::sat_sample(mbp_pkg::POLE_W'(level_nxt)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (step && cfg_r.enabled) begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.bus_value = out_data_r;

  `MBP_ASSERT_NOW(a_level_range, 1'b1, (level_r >= -mbp_pkg::ONE_LVL) && (level_r <= mbp_pkg::ONE_LVL), "level left full-scale range")
  `MBP_ASSERT_NEXT(a_disabled_keeps_level, step && !cfg_r.enabled, $stable(level_r), "level changed on a disabled bus")
  `MBP_ASSERT_NEXT(a_disabled_zero, step && !cfg_r.enabled, out_data_r == '0, "disabled bus gave a nonzero word")
  `MBP_ASSERT_NEXT(a_step_fills_out, step, out_v_r, "advanced word did not reach the output register")

endmodule

/* dv/tb_modulation_bus_processor.sv */
// Self-checking testbench for the modulation bus processor: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb_modulation_bus_processor;

  localparam int         LIMIT_CYCLES    = 400000;
  localparam int         RAND_PHASES     = 18;
  localparam int         PHASE_WORDS     = 36;
  localparam logic [3:0] OP_FIRST_UNUSED = 4'd11;
  localparam logic [3:0] OP_LAST_CODE    = 4'd15;
  localparam longint     SAT_HI          = mbp_pkg::ONE_I - 1;
  localparam longint     SAT_LO          = -mbp_pkg::ONE_I;
  localparam longint     ATK_TARGET      = mbp_pkg::ONE_I + mbp_pkg::OVER_I;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [mbp_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [mbp_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mbp_in_if  in_ch ();
  mbp_out_if out_ch ();

  modulation_bus_processor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Register image as seen by the bus
  logic                       reg_enabled    = 1'b0;
  logic [3:0]                 reg_op         = '0;
  logic [mbp_pkg::THR_W-1:0]  reg_threshold  = '0;
  logic [mbp_pkg::HOLD_W-1:0] reg_hold_ticks = '0;
  logic [mbp_pkg::COEF_W-1:0] reg_coef_up    = '0;
  logic [mbp_pkg::COEF_W-1:0] reg_coef_down  = '0;
  logic [mbp_pkg::STEP_W-1:0] reg_step_up    = '1;
  logic [mbp_pkg::STEP_W-1:0] reg_step_down  = '1;

  // Bus state mirrored by the predictor
  logic signed [mbp_pkg::LVL_W-1:0] env_level     = '0;
  logic [mbp_pkg::THR_W-1:0]        env_prev_mag  = '0;
  mbp_pkg::env_phase_t              env_phase     = mbp_pkg::PH_IDLE;
  logic [mbp_pkg::HOLD_W-1:0]       env_hold_left = '0;

  logic signed [mbp_pkg::SAMPLE_W-1:0] pending_bus_q[$];

  int cycle_cnt  = 0;
  int n_errors   = 0;
  int n_checked  = 0;
  int n_writes   = 0;
  int stall_left = 0;
  bit burst_mode = 1'b0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d words still pending", $time, pending_bus_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Clamp to the sample range
  function automatic longint clip_level(input longint x);
    return (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
  endfunction

  // Q0.16 coefficient times a difference, rounded half up
  function automatic longint retain_q16(input logic [mbp_pkg::COEF_W-1:0] c, input longint d);
    return (longint'(c) * d + 32768) >>> 16;
  endfunction

  // Advance the bus by one tick and return the expected bus value
  function automatic logic signed [mbp_pkg::SAMPLE_W-1:0] next_bus_value(
    input logic signed [mbp_pkg::SAMPLE_W-1:0] a_in,
    input logic signed [mbp_pkg::SAMPLE_W-1:0] b_in
  );
    longint a, b, v, d, lvl;
    if (!reg_enabled) return '0;
    a   = a_in;
    b   = b_in;
    lvl = env_level;
    case (reg_op)
      mbp_pkg::OP_ADD:   lvl = clip_level(a + b);
      mbp_pkg::OP_MUL:   lvl = clip_level((a * b + (mbp_pkg::ONE_I >>> 1)) >>> mbp_pkg::FRAC_W);
      mbp_pkg::OP_MIN:   lvl = (a < b) ? a : b;
      mbp_pkg::OP_MAX:   lvl = (a > b) ? a : b;
      mbp_pkg::OP_GATE:  lvl = (a > 0) ? b : 0;
      mbp_pkg::OP_XFADE: lvl = (a + b) >>> 1;
      mbp_pkg::OP_DIFF: begin
        d   = a - b;
        lvl = clip_level((d < 0) ? -d : d);
      end
      mbp_pkg::OP_FOLLOW: begin
        v   = (a < 0) ? -a : a;
        lvl = v + retain_q16((v > lvl) ? reg_coef_up : reg_coef_down, lvl - v);
        if (lvl < 0) lvl = 0;
        if (lvl > mbp_pkg::ONE_I) lvl = mbp_pkg::ONE_I;
      end
      mbp_pkg::OP_TRIGGER: begin
        v = (a < 0) ? -a : a;
        if (v > SAT_HI) v = SAT_HI;
        // Retrigger only on an upward crossing while idle or decaying
        if (v > longint'(reg_threshold) && env_prev_mag <= reg_threshold &&
            (env_phase == mbp_pkg::PH_IDLE || env_phase == mbp_pkg::PH_DECAY)) begin
          env_phase     = mbp_pkg::PH_ATTACK;
          env_hold_left = reg_hold_ticks;
        end
        case (env_phase)
          mbp_pkg::PH_IDLE: lvl = 0;
          mbp_pkg::PH_ATTACK: begin
            lvl = ATK_TARGET + retain_q16(reg_coef_up, lvl - ATK_TARGET);
            if (lvl >= mbp_pkg::ONE_I) begin
              lvl       = mbp_pkg::ONE_I;
              env_phase = (reg_hold_ticks != 0) ? mbp_pkg::PH_HOLD : mbp_pkg::PH_DECAY;
            end
          end
          mbp_pkg::PH_HOLD: begin
            lvl = mbp_pkg::ONE_I;
            if (env_hold_left != 0) env_hold_left--;
            if (env_hold_left == 0) env_phase = mbp_pkg::PH_DECAY;
          end
          default: begin
            lvl = -mbp_pkg::OVER_I + retain_q16(reg_coef_down, lvl + mbp_pkg::OVER_I);
            if (lvl <= mbp_pkg::END_I) begin
              lvl       = 0;
              env_phase = mbp_pkg::PH_IDLE;
            end
          end
        endcase
        env_prev_mag = mbp_pkg::THR_W'(v);
      end
      mbp_pkg::OP_SLEWEXP:
        lvl = a + retain_q16((a > lvl) ? reg_coef_up : reg_coef_down, lvl - a);
      mbp_pkg::OP_SLEWLIN: begin
        d = a - lvl;
        if (d > longint'(reg_step_up)) d = longint'(reg_step_up);
        if (d < -longint'(reg_step_down)) d = -longint'(reg_step_down);
        lvl = lvl + d;
      end
      default: lvl = 0;
    endcase
    env_level = mbp_pkg::LVL_W'(lvl);
    return mbp_pkg::SAMPLE_W'(clip_level(lvl));
  endfunction

  // Result side: check each word against the oldest expectation, then stall at random outside burst mode
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bus_q.size() == 0) begin
        $display("%0t: unexpected word, bus_value %0d", $time, out_ch.bus_value);
        n_errors++;
      end else begin
        if (out_ch.bus_value !== pending_bus_q[0]) begin
          $display("%0t: bus_value mismatch, expected %0d, actual %0d",
                   $time, pending_bus_q[0], out_ch.bus_value);
          n_errors++;
        end
        void'(pending_bus_q.pop_front());
        n_checked++;
      end
      stall_left = burst_mode ? 0 : $urandom_range(0, 3);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_ch.ready <= (stall_left == 0);
  end

  // Drop valid and hold until every expected word has come back
  task automatic settle_bus();
    in_ch.valid <= 1'b0;
    while (pending_bus_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Send one word after a random gap (none in burst mode) and record its expected result
  task automatic send_word(input logic signed [mbp_pkg::SAMPLE_W-1:0] a,
                           input logic signed [mbp_pkg::SAMPLE_W-1:0] b);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.sample_a <= a;
    in_ch.sample_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_bus_q.push_back(next_bus_value(a, b));
  endtask

  // Write one register once the bus is idle
  task automatic write_reg(input mbp_pkg::cfg_idx_t idx,
                           input logic [mbp_pkg::CFG_DATA_W-1:0] val);
    settle_bus();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      mbp_pkg::REG_ENABLED:    reg_enabled    = val[0];
      mbp_pkg::REG_OP:         reg_op         = val[3:0];
      mbp_pkg::REG_THRESHOLD:  reg_threshold  = val[mbp_pkg::THR_W-1:0];
      mbp_pkg::REG_HOLD_TICKS: reg_hold_ticks = val[mbp_pkg::HOLD_W-1:0];
      mbp_pkg::REG_COEF_UP:    reg_coef_up    = val[mbp_pkg::COEF_W-1:0];
      mbp_pkg::REG_COEF_DOWN:  reg_coef_down  = val[mbp_pkg::COEF_W-1:0];
      mbp_pkg::REG_STEP_UP:    reg_step_up    = val[mbp_pkg::STEP_W-1:0];
      mbp_pkg::REG_STEP_DOWN:  reg_step_down  = val[mbp_pkg::STEP_W-1:0];
      default: ;
    endcase
    n_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Coefficient or step value, leaning on the extremes
  function automatic logic [mbp_pkg::CFG_DATA_W-1:0] pick_reg_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return mbp_pkg::CFG_DATA_W'($urandom);
      default: return mbp_pkg::CFG_DATA_W'($urandom_range(0, 56000));
    endcase
  endfunction

  // Reset values: disabled bus, then linear slew with the default full steps
  task automatic test_reset_state();
    send_word(mbp_pkg::SAMPLE_W'(SAT_HI), mbp_pkg::SAMPLE_W'(SAT_LO));
    write_reg(mbp_pkg::REG_ENABLED, mbp_pkg::CFG_DATA_W'(1));
    write_reg(mbp_pkg::REG_OP, mbp_pkg::CFG_DATA_W'(mbp_pkg::OP_SLEWLIN));
    send_word(mbp_pkg::SAMPLE_W'(SAT_LO), '0);
    send_word(mbp_pkg::SAMPLE_W'(SAT_HI), '0);
  endtask

  // Every combinator at full-scale corners, then an unused op code
  task automatic test_combinators();
    for (int k = mbp_pkg::OP_ADD; k <= mbp_pkg::OP_DIFF; k++) begin
      write_reg(mbp_pkg::REG_OP, mbp_pkg::CFG_DATA_W'(k));
      send_word(mbp_pkg::SAMPLE_W'(SAT_LO), mbp_pkg::SAMPLE_W'(SAT_LO));
      send_word(mbp_pkg::SAMPLE_W'(SAT_HI), mbp_pkg::SAMPLE_W'(SAT_LO));
    end
    write_reg(mbp_pkg::REG_OP, mbp_pkg::CFG_DATA_W'(OP_LAST_CODE));
    send_word(16'sd1000, 16'sd2000);
  endtask

  // Limited linear slew; a disabled bus outputs zero and keeps its level
  task automatic test_slew_hold();
    write_reg(mbp_pkg::REG_OP, mbp_pkg::CFG_DATA_W'(mbp_pkg::OP_SLEWLIN));
    write_reg(mbp_pkg::REG_STEP_UP, mbp_pkg::CFG_DATA_W'(300));
    send_word(16'sd12345, '0);
    write_reg(mbp_pkg::REG_ENABLED, mbp_pkg::CFG_DATA_W'(0));
    send_word(-16'sd5, '0);
    write_reg(mbp_pkg::REG_ENABLED, mbp_pkg::CFG_DATA_W'(1));
    write_reg(mbp_pkg::REG_STEP_UP, mbp_pkg::CFG_DATA_W'(0));
    write_reg(mbp_pkg::REG_STEP_DOWN, mbp_pkg::CFG_DATA_W'(0));
    send_word(mbp_pkg::SAMPLE_W'(SAT_LO), '0);
  endtask

  // Follower and triggered envelope corners
  task automatic test_envelope();
    // full-scale negative magnitude in the follower
    write_reg(mbp_pkg::REG_OP, mbp_pkg::CFG_DATA_W'(mbp_pkg::OP_FOLLOW));
    write_reg(mbp_pkg::REG_COEF_DOWN, 16'hFFFF);
    send_word(mbp_pkg::SAMPLE_W'(SAT_LO), '0);
    send_word('0, '0);
    // full-scale negative trigger, no hold, instant attack and decay
    write_reg(mbp_pkg::REG_OP, mbp_pkg::CFG_DATA_W'(mbp_pkg::OP_TRIGGER));
    write_reg(mbp_pkg::REG_THRESHOLD, mbp_pkg::CFG_DATA_W'(32766));
    write_reg(mbp_pkg::REG_COEF_DOWN, mbp_pkg::CFG_DATA_W'(0));
    send_word(mbp_pkg::SAMPLE_W'(SAT_LO), '0);
    send_word('0, '0);
    // attack starts with a zero hold count, then hold is enabled mid-attack
    write_reg(mbp_pkg::REG_THRESHOLD, mbp_pkg::CFG_DATA_W'(0));
    write_reg(mbp_pkg::REG_COEF_UP, mbp_pkg::CFG_DATA_W'(60000));
    send_word(16'sd20000, '0);
    write_reg(mbp_pkg::REG_HOLD_TICKS, mbp_pkg::CFG_DATA_W'(3));
    write_reg(mbp_pkg::REG_COEF_UP, mbp_pkg::CFG_DATA_W'(0));
    send_word(16'sd20000, '0);
    send_word('0, '0);
    send_word('0, '0);
  endtask

  // Random register settings, each followed by random samples
  task automatic test_random_traffic();
    logic [3:0]                          code;
    logic                                en;
    logic [mbp_pkg::CFG_DATA_W-1:0]      thr_word;
    logic [mbp_pkg::CFG_DATA_W-1:0]      hold_word;
    logic [mbp_pkg::THR_W-1:0]           thr;
    logic signed [mbp_pkg::SAMPLE_W-1:0] a;
    logic                                run_high;
    int                                  run_left;
    int                                  mag;
    run_high = 1'b0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      // pick the setting: every op once, then mostly stateful ops
      if (p <= mbp_pkg::OP_SLEWLIN) begin
        code = 4'(p);
      end else if ($urandom_range(0, 6) == 0) begin
        code = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
      end else if (p % 2 == 1) begin
        code = mbp_pkg::OP_TRIGGER;
      end else begin
        code = 4'($urandom_range(mbp_pkg::OP_FOLLOW, mbp_pkg::OP_SLEWLIN));
      end
      en = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 7))
        0:       thr_word = '0;
        1:       thr_word = 16'h7FFF;
        2:       thr_word = mbp_pkg::CFG_DATA_W'($urandom);
        default: thr_word = mbp_pkg::CFG_DATA_W'($urandom_range(2000, 28000));
      endcase
      if (p == RAND_PHASES - 1) hold_word = '1;
      else if ($urandom_range(0, 9) == 0) hold_word = mbp_pkg::CFG_DATA_W'($urandom);
      else hold_word = mbp_pkg::CFG_DATA_W'($urandom_range(0, 6));
      thr = thr_word[mbp_pkg::THR_W-1:0];

      write_reg(mbp_pkg::REG_ENABLED, {15'($urandom), en});
      write_reg(mbp_pkg::REG_OP, {12'($urandom), code});
      write_reg(mbp_pkg::REG_THRESHOLD, thr_word);
      write_reg(mbp_pkg::REG_HOLD_TICKS, hold_word);
      write_reg(mbp_pkg::REG_COEF_UP, pick_reg_value());
      write_reg(mbp_pkg::REG_COEF_DOWN, pick_reg_value());
      write_reg(mbp_pkg::REG_STEP_UP, pick_reg_value());
      write_reg(mbp_pkg::REG_STEP_DOWN, pick_reg_value());

      burst_mode = (p % 4 == 3);
      run_left   = 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // hold off the sender until the bus has drained
        if (n == PHASE_WORDS / 2 && p % 5 == 2) settle_bus();
        if (code == mbp_pkg::OP_TRIGGER && $urandom_range(0, 9) != 0) begin
          // alternate runs above and below the threshold
          if (run_left == 0) begin
            run_high = !run_high;
            run_left = $urandom_range(1, 6);
          end
          run_left--;
          mag = run_high ? $urandom_range(32767, int'(thr) + 1) : $urandom_range(0, thr);
          a   = mbp_pkg::SAMPLE_W'($urandom_range(0, 1) ? -mag : mag);
        end else begin
          case ($urandom_range(0, 15))
            0:       a = mbp_pkg::SAMPLE_W'(SAT_LO);
            1:       a = mbp_pkg::SAMPLE_W'(SAT_HI);
            2:       a = '0;
            3:       a = '1;
            default: a = mbp_pkg::SAMPLE_W'($urandom);
          endcase
        end
        send_word(a, mbp_pkg::SAMPLE_W'($urandom));
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.sample_a <= '0;
    in_ch.sample_b <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= mbp_pkg::REG_ENABLED;
    cfg_wdata      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_combinators();
    test_slew_hold();
    test_envelope();
    test_random_traffic();
    settle_bus();

    $display("Summary: %0d words checked across %0d register writes", n_checked, n_writes);
    $display("Summary: all ops, unused codes, disabled bus, envelope phases, random stalls");
    if (n_errors == 0 && pending_bus_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
